### src/cssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// cssc_pkg: shared constants, register indexes and sequencer states
// for the clutch slip sweep controller. no dependencies.

package cssc_pkg;

  // encoder count width on the input channel
  localparam int COUNT_WIDTH = 16;
  // configuration register width
  localparam int CFG_W = 16;
  // width used to clamp a raw count against max_count
  localparam int FOLD_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  localparam int NUM_COUNTS = 3;
  localparam int IDX_W = $clog2(NUM_COUNTS);

  // percentage arithmetic
  localparam int PCT_W = 6;
  localparam int PCT_TOTAL_W = 7;
  localparam logic [PCT_W-1:0] PERCENT_FULL = PCT_W'(50);
  localparam logic [PCT_TOTAL_W-1:0] PERCENT_TOTAL = PCT_TOTAL_W'(100);

  // sweep_position * 50 and the restoring divider over it
  localparam int PROD_W = CFG_W + PCT_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  // apb register map, 4 bytes per register
  localparam int NUM_REGS = 8;
  localparam int ADDR_W = $clog2(NUM_REGS) + 2;
  localparam int APB_DATA_W = 32;

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_TOLERANCE    = 3'd0,
    REG_MAX_COUNT    = 3'd1,
    REG_BIN_AWD_CMP  = 3'd2,
    REG_BIN_RWD_CMP  = 3'd3,
    REG_DYN_AWD_LIM  = 3'd4,
    REG_DYN_RWD_LIM  = 3'd5,
    REG_SWEEP_STEP   = 3'd6,
    REG_SWEEP_DELAY  = 3'd7
  } reg_idx_t;

  // reset values
  localparam logic [CFG_W-1:0] RST_TOLERANCE   = CFG_W'(150);
  localparam logic [CFG_W-1:0] RST_MAX_COUNT   = CFG_W'(4600);
  localparam logic [CFG_W-1:0] RST_BIN_AWD_CMP = CFG_W'(258);
  localparam logic [CFG_W-1:0] RST_BIN_RWD_CMP = CFG_W'(265);
  localparam logic [CFG_W-1:0] RST_DYN_AWD_LIM = CFG_W'(0);
  localparam logic [CFG_W-1:0] RST_DYN_RWD_LIM = CFG_W'(12375);
  localparam logic [CFG_W-1:0] RST_SWEEP_STEP  = CFG_W'(25);
  localparam logic [CFG_W-1:0] RST_SWEEP_DELAY = CFG_W'(1000);
  localparam logic [CFG_W-1:0] RST_SWEEP_POS   = CFG_W'(12375);
  localparam logic [CFG_W-1:0] TICK_MAX        = '1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_FOLD   = 3'd1,
    ST_DIFF   = 3'd2,
    ST_SLIP   = 3'd3,
    ST_MULT   = 3'd4,
    ST_DIV    = 3'd5,
    ST_UPDATE = 3'd6,
    ST_FINISH = 3'd7
  } state_t;

endpackage

`default_nettype wire

### src/cssc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// cssc_in_if: valid/ready channel carrying one tick of encoder counts.
// depends on cssc_pkg for the count width.

interface cssc_in_if;
  logic                             valid;
  logic                             ready;
  logic [cssc_pkg::COUNT_WIDTH-1:0] front_left_count;
  logic [cssc_pkg::COUNT_WIDTH-1:0] front_right_count;
  logic [cssc_pkg::COUNT_WIDTH-1:0] rear_count;

  modport source (output valid, front_left_count, front_right_count, rear_count,
                  input ready);
  modport sink (input valid, front_left_count, front_right_count, rear_count,
                output ready);
endinterface

`default_nettype wire

### src/cssc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// cssc_out_if: valid/ready channel carrying one controller result per tick.
// depends on cssc_pkg for field widths.

interface cssc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 awd_request;
  logic [cssc_pkg::CFG_W-1:0]           binary_compare;
  logic [cssc_pkg::CFG_W-1:0]           dynamic_compare;
  logic [cssc_pkg::PCT_W-1:0]           awd_percent;
  logic [cssc_pkg::PCT_TOTAL_W-1:0]     rwd_percent;
  logic [cssc_pkg::CFG_W-1:0]           turn_difference;
  logic [cssc_pkg::CFG_W-1:0]           slip_difference;

  modport source (output valid, awd_request, binary_compare, dynamic_compare,
                  awd_percent, rwd_percent, turn_difference, slip_difference,
                  input ready);
  modport sink (input valid, awd_request, binary_compare, dynamic_compare,
                awd_percent, rwd_percent, turn_difference, slip_difference,
                output ready);
endinterface

`default_nettype wire

### src/clutch_slip_sweep_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// clutch_slip_sweep_controller_top: clutch slip detection and sweep control.
// depends on cssc_pkg, cssc_in_if and cssc_out_if.
//
// usage:
//   sample  - one beat per control tick: front left, front right and rear
//             encoder counts. taken only while the sequencer is idle.
//   result  - one beat per tick: awd request, binary and dynamic servo
//             compare values, awd/rwd percent split, turn and slip differences.
//   apb     - eight 16 bit registers at byte offsets 0x00..0x1c. the user
//             must write them only while idle; the block does not enforce it.
//             pready is tied high, reads return data.
// sequence:
//   an item runs from its sample beat to its result beat through a fold step per
//   count, the difference and slip steps, a multiply step, the restoring divider
//   (one quotient bit per cycle through one shared subtractor), a sweep update
//   step and a finish step that loads the result register. the next sample is
//   taken the cycle after that load, and not before the last item is through.
// stall:
//   the result register holds its beat until taken; a new sample may be taken
//   meanwhile, and that item waits in its last step if the register is full.
// reset:
//   rst is synchronous; registers go to their documented defaults, the sweep
//   position to the rwd limit, the step counter to zero, no beat pending.

module clutch_slip_sweep_controller_top (
  input  wire                                 clk,
  input  wire                                 rst,
  cssc_in_if.sink                             sample,
  cssc_out_if.source                          result,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [cssc_pkg::ADDR_W-1:0]         paddr,
  input  wire  [cssc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cssc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CW = cssc_pkg::CFG_W;

  // configuration registers
  logic [CW-1:0] tolerance;
  logic [CW-1:0] max_count;
  logic [CW-1:0] binary_awd_compare;
  logic [CW-1:0] binary_rwd_compare;
  logic [CW-1:0] dynamic_awd_limit;
  logic [CW-1:0] dynamic_rwd_limit;
  logic [CW-1:0] sweep_step;
  logic [CW-1:0] sweep_delay;

  // persistent state
  logic [CW-1:0] sweep_position;
  logic [CW-1:0] tick_since_step;
  logic [CW-1:0] sweep_position_next;
  logic [CW-1:0] tick_since_step_next;

  // sequencer
  cssc_pkg::state_t state;
  cssc_pkg::state_t state_next;
  logic [cssc_pkg::IDX_W-1:0]     fold_idx;
  logic [cssc_pkg::DIV_CNT_W-1:0] div_cnt;

  // per item working registers
  logic [cssc_pkg::COUNT_WIDTH-1:0] raw_count [cssc_pkg::NUM_COUNTS];
  logic [CW-1:0] fold_count [cssc_pkg::NUM_COUNTS];
  logic [CW-1:0] turn;
  logic [CW-1:0] avg;
  logic [CW-1:0] slip;
  logic          awd;
  logic [cssc_pkg::PROD_W-1:0] div_quo;
  logic [CW-1:0]               div_rem;
  logic [cssc_pkg::PCT_W-1:0]  awd_pct;

  // output register
  logic                             out_valid;
  logic                             out_awd;
  logic [CW-1:0]                    out_bin;
  logic [CW-1:0]                    out_dyn;
  logic [cssc_pkg::PCT_W-1:0]       out_awd_pct;
  logic [cssc_pkg::PCT_TOTAL_W-1:0] out_rwd_pct;
  logic [CW-1:0]                    out_turn;
  logic [CW-1:0]                    out_slip;

  // control decoded from the state and the apb bus
  logic sample_ready;
  logic load_out;
  logic cfg_write;
  cssc_pkg::reg_idx_t cfg_idx;

  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = cssc_pkg::reg_idx_t'(paddr[cssc_pkg::ADDR_W-1:2]);
  assign pready    = 1'b1;

  // ---------------------------------------------------------------- apb
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance          <= cssc_pkg::RST_TOLERANCE;
      max_count          <= cssc_pkg::RST_MAX_COUNT;
      binary_awd_compare <= cssc_pkg::RST_BIN_AWD_CMP;
      binary_rwd_compare <= cssc_pkg::RST_BIN_RWD_CMP;
      dynamic_awd_limit  <= cssc_pkg::RST_DYN_AWD_LIM;
      dynamic_rwd_limit  <= cssc_pkg::RST_DYN_RWD_LIM;
      sweep_step         <= cssc_pkg::RST_SWEEP_STEP;
      sweep_delay        <= cssc_pkg::RST_SWEEP_DELAY;
    end else if (cfg_write) begin
      case (cfg_idx)
        cssc_pkg::REG_TOLERANCE:   tolerance          <= pwdata[CW-1:0];
        cssc_pkg::REG_MAX_COUNT:   max_count          <= pwdata[CW-1:0];
        cssc_pkg::REG_BIN_AWD_CMP: binary_awd_compare <= pwdata[CW-1:0];
        cssc_pkg::REG_BIN_RWD_CMP: binary_rwd_compare <= pwdata[CW-1:0];
        cssc_pkg::REG_DYN_AWD_LIM: dynamic_awd_limit  <= pwdata[CW-1:0];
        cssc_pkg::REG_DYN_RWD_LIM: dynamic_rwd_limit  <= pwdata[CW-1:0];
        cssc_pkg::REG_SWEEP_STEP:  sweep_step         <= pwdata[CW-1:0];
        cssc_pkg::REG_SWEEP_DELAY: sweep_delay        <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cssc_pkg::REG_TOLERANCE:   prdata = cssc_pkg::APB_DATA_W'(tolerance);
      cssc_pkg::REG_MAX_COUNT:   prdata = cssc_pkg::APB_DATA_W'(max_count);
      cssc_pkg::REG_BIN_AWD_CMP: prdata = cssc_pkg::APB_DATA_W'(binary_awd_compare);
      cssc_pkg::REG_BIN_RWD_CMP: prdata = cssc_pkg::APB_DATA_W'(binary_rwd_compare);
      cssc_pkg::REG_DYN_AWD_LIM: prdata = cssc_pkg::APB_DATA_W'(dynamic_awd_limit);
      cssc_pkg::REG_DYN_RWD_LIM: prdata = cssc_pkg::APB_DATA_W'(dynamic_rwd_limit);
      cssc_pkg::REG_SWEEP_STEP:  prdata = cssc_pkg::APB_DATA_W'(sweep_step);
      cssc_pkg::REG_SWEEP_DELAY: prdata = cssc_pkg::APB_DATA_W'(sweep_delay);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cssc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cssc_pkg::ST_IDLE: begin
        if (sample.valid) state_next = cssc_pkg::ST_FOLD;
      end
      cssc_pkg::ST_FOLD: begin
        if (fold_idx == cssc_pkg::IDX_W'(cssc_pkg::NUM_COUNTS - 1)) begin
          state_next = cssc_pkg::ST_DIFF;
        end
      end
      cssc_pkg::ST_DIFF: state_next = cssc_pkg::ST_SLIP;
      cssc_pkg::ST_SLIP: state_next = cssc_pkg::ST_MULT;
      cssc_pkg::ST_MULT: state_next = cssc_pkg::ST_DIV;
      cssc_pkg::ST_DIV: begin
        if (div_cnt == cssc_pkg::DIV_CNT_W'(cssc_pkg::PROD_W - 1)) begin
          state_next = cssc_pkg::ST_UPDATE;
        end
      end
      cssc_pkg::ST_UPDATE: state_next = cssc_pkg::ST_FINISH;
      cssc_pkg::ST_FINISH: begin
        if (!out_valid || result.ready) state_next = cssc_pkg::ST_IDLE;
      end
      default: state_next = cssc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    load_out     = 1'b0;
    case (state)
      cssc_pkg::ST_IDLE:   sample_ready = 1'b1;
      cssc_pkg::ST_FINISH: load_out     = !out_valid || result.ready;
      default: ;
    endcase
  end

  assign sample.ready = sample_ready;

  // ---------------------------------------------------------- fold unit
  logic [cssc_pkg::FOLD_W-1:0] raw_ext;
  logic [cssc_pkg::FOLD_W-1:0] max_ext;
  logic [CW-1:0]               clamped;
  logic [CW-1:0]               rest;
  logic [CW-1:0]               folded;

  always_comb begin
    raw_ext = cssc_pkg::FOLD_W'(raw_count[fold_idx]);
    max_ext = cssc_pkg::FOLD_W'(max_count);
    clamped = (raw_ext > max_ext) ? max_count : raw_ext[CW-1:0];
    rest    = max_count - clamped;
    folded  = (rest < clamped) ? rest : clamped;
  end

  // ---------------------------------------------------- difference logic
  logic [CW-1:0] fl_f;
  logic [CW-1:0] fr_f;
  logic [CW-1:0] rr_f;
  logic [CW:0]   front_sum;

  assign fl_f      = fold_count[0];
  assign fr_f      = fold_count[1];
  assign rr_f      = fold_count[2];
  assign front_sum = {1'b0, fl_f} + {1'b0, fr_f};

  // ------------------------------------------- shared divider subtractor
  logic [CW:0]   rem_shift;
  logic [CW+1:0] sub_res;
  logic          sub_borrow;

  assign rem_shift  = {div_rem, div_quo[cssc_pkg::PROD_W-1]};
  assign sub_res    = {1'b0, rem_shift} - {2'b00, dynamic_rwd_limit};
  assign sub_borrow = sub_res[CW+1];

  // ------------------------------------------------------ sweep update
  logic [CW-1:0]              awd_room;
  logic [CW-1:0]              rwd_room;
  logic                       step_ready;
  logic [cssc_pkg::PCT_W-1:0] quo_sat;

  always_comb begin
    step_ready           = tick_since_step >= sweep_delay;
    awd_room             = sweep_position - dynamic_awd_limit;
    rwd_room             = dynamic_rwd_limit - sweep_position;
    sweep_position_next  = sweep_position;
    tick_since_step_next = tick_since_step;
    if (awd) begin
      if (sweep_position > dynamic_awd_limit && step_ready) begin
        sweep_position_next  = (sweep_step >= awd_room) ? dynamic_awd_limit
                                                         : sweep_position - sweep_step;
        tick_since_step_next = '0;
      end
    end else begin
      if (sweep_position < dynamic_rwd_limit && step_ready) begin
        sweep_position_next  = (sweep_step >= rwd_room) ? dynamic_rwd_limit
                                                         : sweep_position + sweep_step;
        tick_since_step_next = '0;
      end
    end
    if (tick_since_step_next != cssc_pkg::TICK_MAX) begin
      tick_since_step_next = tick_since_step_next + CW'(1);
    end
    // quotient above full scale, including a zero divisor, saturates
    quo_sat = (div_quo > cssc_pkg::PROD_W'(cssc_pkg::PERCENT_FULL))
              ? cssc_pkg::PERCENT_FULL : div_quo[cssc_pkg::PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_position  <= cssc_pkg::RST_SWEEP_POS;
      tick_since_step <= '0;
    end else if (state == cssc_pkg::ST_UPDATE) begin
      sweep_position  <= sweep_position_next;
      tick_since_step <= tick_since_step_next;
    end
  end

  // ------------------------------------------------------------ datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_idx <= '0;
      div_cnt  <= '0;
    end else begin
      case (state)
        cssc_pkg::ST_IDLE: begin
          fold_idx <= '0;
          div_cnt  <= '0;
        end
        cssc_pkg::ST_FOLD: fold_idx <= fold_idx + cssc_pkg::IDX_W'(1);
        cssc_pkg::ST_DIV:  div_cnt  <= div_cnt + cssc_pkg::DIV_CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cssc_pkg::ST_IDLE: begin
        raw_count[0] <= sample.front_left_count;
        raw_count[1] <= sample.front_right_count;
        raw_count[2] <= sample.rear_count;
      end
      cssc_pkg::ST_FOLD: fold_count[fold_idx] <= folded;
      cssc_pkg::ST_DIFF: begin
        turn <= (fr_f >= fl_f) ? fr_f - fl_f : fl_f - fr_f;
        avg  <= front_sum[CW:1];
      end
      cssc_pkg::ST_SLIP: begin
        slip <= (rr_f >= avg) ? rr_f - avg : avg - rr_f;
        awd  <= (turn > tolerance) ||
                (((rr_f >= avg) ? rr_f - avg : avg - rr_f) > tolerance && rr_f > avg);
      end
      cssc_pkg::ST_MULT: begin
        div_quo <= cssc_pkg::PROD_W'(sweep_position) *
                   cssc_pkg::PROD_W'(cssc_pkg::PERCENT_FULL);
        div_rem <= '0;
      end
      cssc_pkg::ST_DIV: begin
        // restoring division, one quotient bit per cycle
        div_quo <= {div_quo[cssc_pkg::PROD_W-2:0], !sub_borrow};
        div_rem <= sub_borrow ? rem_shift[CW-1:0] : sub_res[CW-1:0];
      end
      cssc_pkg::ST_UPDATE: awd_pct <= cssc_pkg::PERCENT_FULL - quo_sat;
      default: ;
    endcase
  end

  // ------------------------------------------------------ result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_awd     <= awd;
      out_bin     <= awd ? binary_awd_compare : binary_rwd_compare;
      out_dyn     <= sweep_position;
      out_awd_pct <= awd_pct;
      out_rwd_pct <= cssc_pkg::PERCENT_TOTAL - cssc_pkg::PCT_TOTAL_W'(awd_pct);
      out_turn    <= turn;
      out_slip    <= slip;
    end
  end

  assign result.valid           = out_valid;
  assign result.awd_request     = out_awd;
  assign result.binary_compare  = out_bin;
  assign result.dynamic_compare = out_dyn;
  assign result.awd_percent     = out_awd_pct;
  assign result.rwd_percent     = out_rwd_pct;
  assign result.turn_difference = out_turn;
  assign result.slip_difference = out_slip;

  // ---------------------------------------------------------- assertions
  a_sample_starts_fold: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> state == cssc_pkg::ST_FOLD)
    else $error("sample beat did not start the fold step");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == cssc_pkg::ST_FINISH))
    else $error("result beat raised outside the finish step");

  a_percent_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_awd_pct <= cssc_pkg::PERCENT_FULL &&
                   cssc_pkg::PCT_TOTAL_W'(out_awd_pct) + out_rwd_pct ==
                   cssc_pkg::PERCENT_TOTAL))
    else $error("awd and rwd percent do not split 100");

  a_tick_after_update: assert property (@(posedge clk) disable iff (rst)
    $past(state == cssc_pkg::ST_UPDATE) |-> tick_since_step != '0)
    else $error("step counter zero after a sweep update");

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// testbench: directed and random checks of clutch_slip_sweep_controller_top, with an
// in-line prediction of count folding, slip/turn detection and the rate-limited sweep.
// depends on cssc_pkg, cssc_in_if, cssc_out_if and the top level.

module testbench;
  import cssc_pkg::*;

  typedef struct packed {
    logic                   awd_request;
    logic [CFG_W-1:0]       binary_compare;
    logic [CFG_W-1:0]       dynamic_compare;
    logic [PCT_W-1:0]       awd_percent;
    logic [PCT_TOTAL_W-1:0] rwd_percent;
    logic [CFG_W-1:0]       turn_difference;
    logic [CFG_W-1:0]       slip_difference;
  } clutch_result_t;

  typedef enum int {
    DRIVE_STRAIGHT,
    DRIVE_TURN,
    DRIVE_REAR_SLIP,
    DRIVE_REAR_DRAG,
    DRIVE_NOISE
  } drive_style_t;

  localparam int COUNT_MAX = 2 ** COUNT_WIDTH - 1;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cssc_in_if  sample_ch ();
  cssc_out_if result_ch ();

  clutch_slip_sweep_controller_top dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the register file and the sweep state
  logic [CFG_W-1:0] reg_shadow [NUM_REGS];
  logic [CFG_W-1:0] sweep_pos;
  logic [CFG_W-1:0] ticks_since_step;

  clutch_result_t pending_results [$];
  int             mismatch_count = 0;
  bit             quiet_flow = 1'b0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_model();
    reg_shadow[REG_TOLERANCE]   = RST_TOLERANCE;
    reg_shadow[REG_MAX_COUNT]   = RST_MAX_COUNT;
    reg_shadow[REG_BIN_AWD_CMP] = RST_BIN_AWD_CMP;
    reg_shadow[REG_BIN_RWD_CMP] = RST_BIN_RWD_CMP;
    reg_shadow[REG_DYN_AWD_LIM] = RST_DYN_AWD_LIM;
    reg_shadow[REG_DYN_RWD_LIM] = RST_DYN_RWD_LIM;
    reg_shadow[REG_SWEEP_STEP]  = RST_SWEEP_STEP;
    reg_shadow[REG_SWEEP_DELAY] = RST_SWEEP_DELAY;
    sweep_pos = RST_SWEEP_POS;
    ticks_since_step = '0;
  endfunction

  // mostly short gaps, a few long ones, none during a quiet stretch
  function automatic int pick_gap();
    int roll;
    if (quiet_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // clamp to max_count, then fold to the nearer end of the counter range
  function automatic logic [CFG_W-1:0] fold_count(input logic [COUNT_WIDTH-1:0] raw);
    logic [CFG_W-1:0] lim;
    logic [CFG_W-1:0] c;
    logic [CFG_W-1:0] rest;
    lim = reg_shadow[REG_MAX_COUNT];
    c = (raw > lim) ? lim : CFG_W'(raw);
    rest = lim - c;
    return (rest < c) ? rest : c;
  endfunction

  function automatic clutch_result_t compute_clutch_result(
    input logic [COUNT_WIDTH-1:0] fl_raw,
    input logic [COUNT_WIDTH-1:0] fr_raw,
    input logic [COUNT_WIDTH-1:0] rr_raw
  );
    logic [CFG_W-1:0] fl, fr, rr, avg, turn, slip;
    logic [CFG_W-1:0] tol, lim_awd, lim_rwd, step;
    logic             awd;
    logic             may_step;
    int unsigned      quot;
    logic [PCT_W-1:0] awd_pct;
    clutch_result_t   res;
    fl = fold_count(fl_raw);
    fr = fold_count(fr_raw);
    rr = fold_count(rr_raw);
    tol = reg_shadow[REG_TOLERANCE];
    lim_awd = reg_shadow[REG_DYN_AWD_LIM];
    lim_rwd = reg_shadow[REG_DYN_RWD_LIM];
    step = reg_shadow[REG_SWEEP_STEP];
    avg = CFG_W'(({1'b0, fl} + {1'b0, fr}) >> 1);
    turn = (fr > fl) ? fr - fl : fl - fr;
    slip = (rr > avg) ? rr - avg : avg - rr;
    // slip only counts when the rear runs ahead of the front
    awd = (turn > tol) || ((slip > tol) && (rr > avg));
    may_step = ticks_since_step >= reg_shadow[REG_SWEEP_DELAY];

    // percent split uses the position before this tick's step
    if (lim_rwd == '0) begin
      awd_pct = '0;
    end else begin
      quot = (32'(sweep_pos) * 32'(PERCENT_FULL)) / 32'(lim_rwd);
      if (quot > PERCENT_FULL) quot = PERCENT_FULL;
      awd_pct = PERCENT_FULL - PCT_W'(quot);
    end

    if (awd) begin
      if (sweep_pos > lim_awd && may_step) begin
        sweep_pos = (step >= sweep_pos - lim_awd) ? lim_awd : sweep_pos - step;
        ticks_since_step = '0;
      end
      res.binary_compare = reg_shadow[REG_BIN_AWD_CMP];
    end else begin
      if (sweep_pos < lim_rwd && may_step) begin
        sweep_pos = (step >= lim_rwd - sweep_pos) ? lim_rwd : sweep_pos + step;
        ticks_since_step = '0;
      end
      res.binary_compare = reg_shadow[REG_BIN_RWD_CMP];
    end
    if (ticks_since_step != TICK_MAX) ticks_since_step = ticks_since_step + 1'b1;

    res.awd_request = awd;
    res.dynamic_compare = sweep_pos;
    res.awd_percent = awd_pct;
    res.rwd_percent = PERCENT_TOTAL - PCT_TOTAL_W'(awd_pct);
    res.turn_difference = turn;
    res.slip_difference = slip;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic int clip_half(input int v, input int half);
    if (v < 0) return 0;
    if (v > half) return half;
    return v;
  endfunction

  function automatic int wiggle(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // map a folded value back to a raw count, now and then past max_count
  function automatic logic [COUNT_WIDTH-1:0] to_raw(input int v, input int m);
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 8) return COUNT_WIDTH'(v);
    if (pick < 15 || m == COUNT_MAX) return COUNT_WIDTH'(m - v);
    return COUNT_WIDTH'($urandom_range(m + 1, COUNT_MAX));
  endfunction

  // result side: compare each beat with the oldest prediction
  always @(posedge clk) begin : result_check
    clutch_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got dynamic_compare %0d",
                 $time, result_ch.dynamic_compare);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("awd_request", want.awd_request, result_ch.awd_request);
        check_field("binary_compare", want.binary_compare, result_ch.binary_compare);
        check_field("dynamic_compare", want.dynamic_compare, result_ch.dynamic_compare);
        check_field("awd_percent", want.awd_percent, result_ch.awd_percent);
        check_field("rwd_percent", want.rwd_percent, result_ch.rwd_percent);
        check_field("turn_difference", want.turn_difference, result_ch.turn_difference);
        check_field("slip_difference", want.slip_difference, result_ch.slip_difference);
      end
    end
  end

  // result side stalls
  initial begin : result_ready_gen
    int hold;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // valid stays high across back-to-back beats; it is only lowered for a gap or in wait_drained
  task automatic send_tick(input logic [COUNT_WIDTH-1:0] fl, input logic [COUNT_WIDTH-1:0] fr,
                           input logic [COUNT_WIDTH-1:0] rr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.front_left_count <= fl;
    sample_ch.front_right_count <= fr;
    sample_ch.rear_count <= rr;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(compute_clutch_result(fl, fr, rr));
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_shadow[idx] = value;
    @(posedge clk);
  endtask

  // builds counts in folded space so the detection thresholds are hit on purpose
  task automatic send_shaped_tick(input drive_style_t style);
    int m, tol, half, narrow, kick, fl, fr, rr, avg;
    m = int'(reg_shadow[REG_MAX_COUNT]);
    tol = int'(reg_shadow[REG_TOLERANCE]);
    half = m / 2;
    narrow = (tol < half) ? tol : half;
    kick = tol + 1 + $urandom_range(0, half);
    fl = $urandom_range(0, half);
    fr = clip_half(fl + wiggle(narrow), half);
    if (style == DRIVE_TURN) begin
      fr = clip_half($urandom_range(0, 1) ? fl + kick : fl - kick, half);
    end
    avg = (fl + fr) / 2;
    rr = clip_half(avg + wiggle(narrow), half);
    case (style)
      DRIVE_REAR_SLIP: rr = clip_half(avg + kick, half);
      DRIVE_REAR_DRAG: rr = clip_half(avg - kick, half);
      default: ;
    endcase
    if (style == DRIVE_NOISE) begin
      send_tick(COUNT_WIDTH'($urandom), COUNT_WIDTH'($urandom), COUNT_WIDTH'($urandom));
    end else begin
      send_tick(to_raw(fl, m), to_raw(fr, m), to_raw(rr, m));
    end
  endtask

  // reset settings: folding, clamping and both detection thresholds
  task automatic test_detection();
    send_tick(16'd0, 16'd0, 16'd0);
    send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(16'd2301, 16'd4599, 16'd4601);
    send_tick(16'd1000, 16'd1150, 16'd0);
    send_tick(16'd1000, 16'd1151, 16'd0);
    send_tick(16'd1000, 16'd1000, 16'd1151);
    send_tick(16'd1151, 16'd1151, 16'd1000);
  endtask

  // no delay and a huge step: the sweep saturates at each limit in one tick
  task automatic test_sweep_saturation();
    wait_drained();
    write_reg(REG_SWEEP_DELAY, 16'd0);
    write_reg(REG_SWEEP_STEP, 16'hFFFF);
    send_tick(16'd0, 16'd2000, 16'd0);
    send_tick(16'd0, 16'd0, 16'd0);
    send_tick(16'd0, 16'd2000, 16'd0);
  endtask

  task automatic test_limit_corners();
    wait_drained();
    // zero step still clears the delay counter
    write_reg(REG_SWEEP_STEP, 16'd0);
    send_tick(16'd0, 16'd0, 16'd0);
    wait_drained();
    write_reg(REG_SWEEP_STEP, 16'hFFFF);
    send_tick(16'd0, 16'd0, 16'd0);
    // rwd limit below the position: ratio saturates, no move toward rwd
    wait_drained();
    write_reg(REG_DYN_RWD_LIM, 16'd5000);
    write_reg(REG_SWEEP_STEP, 16'd1000);
    send_tick(16'd0, 16'd0, 16'd0);
    send_tick(16'd0, 16'd2000, 16'd0);
    // awd limit above the position: no move toward awd
    wait_drained();
    write_reg(REG_DYN_AWD_LIM, 16'd20000);
    send_tick(16'd0, 16'd2000, 16'd0);
    // zero divisor
    wait_drained();
    write_reg(REG_DYN_RWD_LIM, 16'd0);
    send_tick(16'd0, 16'd0, 16'd0);
    wait_drained();
    write_reg(REG_DYN_AWD_LIM, 16'd0);
    write_reg(REG_DYN_RWD_LIM, RST_DYN_RWD_LIM);
  endtask

  task automatic test_fold_corners();
    wait_drained();
    // zero max_count folds everything to zero
    write_reg(REG_MAX_COUNT, 16'd0);
    send_tick(16'hFFFF, 16'd1, 16'd12345);
    wait_drained();
    write_reg(REG_MAX_COUNT, 16'hFFFF);
    write_reg(REG_TOLERANCE, 16'd0);
    send_tick(16'hFFFF, 16'd0, 16'h8000);
    send_tick(16'h7FFF, 16'h8000, 16'd0);
    send_tick(16'd5, 16'd5, 16'd6);
    wait_drained();
    write_reg(REG_TOLERANCE, 16'hFFFF);
    send_tick(16'd0, 16'h7FFF, 16'h7FFF);
  endtask

  // steps only every few ticks; extreme binary compare values
  task automatic test_step_delay();
    wait_drained();
    write_reg(REG_MAX_COUNT, RST_MAX_COUNT);
    write_reg(REG_TOLERANCE, RST_TOLERANCE);
    write_reg(REG_SWEEP_DELAY, 16'd3);
    write_reg(REG_SWEEP_STEP, 16'd100);
    write_reg(REG_BIN_AWD_CMP, 16'hFFFF);
    write_reg(REG_BIN_RWD_CMP, 16'h0000);
    repeat (3) send_tick(16'd0, 16'd2000, 16'd0);
    send_tick(16'd100, 16'd100, 16'd100);
  endtask

  task automatic write_random_config();
    logic [CFG_W-1:0] m, tol, rl, al, st, dl;
    case ($urandom_range(0, 7))
      0: m = 16'hFFFF;
      1: m = CFG_W'($urandom_range(1, 64));
      default: m = CFG_W'($urandom_range(100, COUNT_MAX));
    endcase
    case ($urandom_range(0, 9))
      0: tol = 16'd0;
      1: tol = 16'hFFFF;
      default: tol = CFG_W'($urandom_range(0, m / 8));
    endcase
    case ($urandom_range(0, 9))
      0: rl = 16'hFFFF;
      1: rl = 16'd0;
      default: rl = CFG_W'($urandom_range(50, COUNT_MAX));
    endcase
    case ($urandom_range(0, 7))
      0: al = 16'd0;
      1: al = CFG_W'($urandom_range(0, COUNT_MAX));
      default: al = CFG_W'($urandom_range(0, rl));
    endcase
    case ($urandom_range(0, 7))
      0: st = 16'hFFFF;
      1: st = 16'd0;
      default: st = CFG_W'($urandom_range(1, rl / 8 + 1));
    endcase
    case ($urandom_range(0, 7))
      0: dl = 16'd0;
      1: dl = 16'hFFFF;
      2: dl = CFG_W'($urandom_range(9, 200));
      default: dl = CFG_W'($urandom_range(0, 8));
    endcase
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_MAX_COUNT, m);
    write_reg(REG_BIN_AWD_CMP, CFG_W'($urandom));
    write_reg(REG_BIN_RWD_CMP, CFG_W'($urandom));
    write_reg(REG_DYN_AWD_LIM, al);
    write_reg(REG_DYN_RWD_LIM, rl);
    write_reg(REG_SWEEP_STEP, st);
    write_reg(REG_SWEEP_DELAY, dl);
  endtask

  // driving styles come in runs so the sweep has time to travel
  task automatic test_random_phases();
    drive_style_t style;
    int           run_left;
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      write_random_config();
      quiet_flow = (phase == 0);
      run_left = 0;
      style = DRIVE_STRAIGHT;
      for (int n = 0; n < 140; n++) begin
        if (n == 70) wait_drained();
        if (run_left == 0) begin
          style = drive_style_t'($urandom_range(0, 4));
          run_left = $urandom_range(1, 40);
        end
        run_left--;
        send_shaped_tick(style);
      end
    end
    quiet_flow = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.front_left_count <= '0;
    sample_ch.front_right_count <= '0;
    sample_ch.rear_count <= '0;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_detection();
    test_sweep_saturation();
    test_limit_corners();
    test_fold_corners();
    test_step_delay();
    test_random_phases();

    wait_drained();
    // catch any stray beat after the last one
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : run_limit
    #(10_000_000);
    $display("timeout at %0t ns, %0d results outstanding", $time, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
